// ===== rtl/sha1md_pkg.sv =====
// Shared types and constants for the SHA-1 message digest unit.
// Used by every module under rtl/; depends on nothing else.
package sha1md_pkg;

  // Input item: one optional message byte and an end-of-message mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  // Result item: one 32-bit word of the digest.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Command passed from the front to the back through the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       eom;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // Command queue geometry (depth is a power of two).
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Message counter and block geometry.
  localparam int COUNT_W      = 61;
  localparam int BLOCK_WORDS  = 16;
  localparam int CV_WORDS     = 5;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_INDEX = 3'd4;

  // Initial chaining values.
  localparam logic [31:0] CV_INIT [CV_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  // First padding byte.
  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

// ===== rtl/sha1_message_digest_unit.sv =====
// SHA-1 message digest unit, top level.
// Instantiates sha1md_front, sha1md_queue and sha1md_core; uses sha1md_pkg.
//
// Input channel (item_valid/item_ready/item): each item carries one
// optional message byte and an end-of-message mark. Items with neither
// are taken and dropped. Output channel (digest_valid/digest_ready/digest):
// five items per message, digest words 0 to 4, most significant first,
// with last_word set on the fifth.
// Flow: the back end takes a byte from the queue while idle, and each full
// 64-byte block is then compressed in 80 rounds of the single round unit
// followed by the chaining add, during which no byte is taken. At the end
// of a message the back end feeds padding one byte per cycle, 9 to 72
// bytes, with one or two block compressions, then presents the five
// words. The front register and a four-entry queue keep accepting items
// while the back end compresses or waits.
// Reset: synchronous and active high; it empties the queue, restores the
// initial chaining values and clears the byte count. If the receiver
// stalls, the current digest word holds and items back up into the queue
// until item_ready drops.
module sha1_message_digest_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  sha1md_pkg::in_item_t  item,
  output logic                  digest_valid,
  input  logic                  digest_ready,
  output sha1md_pkg::out_item_t digest
);

  logic             push_valid;
  logic             push_ready;
  sha1md_pkg::cmd_t push_cmd;
  logic             pop_valid;
  logic             pop_ready;
  sha1md_pkg::cmd_t pop_cmd;

  sha1md_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sha1md_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  sha1md_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (pop_valid),
    .cmd_ready    (pop_ready),
    .cmd          (pop_cmd),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

endmodule

// ===== rtl/sha1md_front.sv =====
// Front end: registers each incoming item and drops items that carry
// neither a byte nor an end mark. Depends on sha1md_pkg.
module sha1md_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  sha1md_pkg::in_item_t item,
  output logic                push_valid,
  input  logic                push_ready,
  output sha1md_pkg::cmd_t    push_cmd
);

  logic             hold_valid;
  sha1md_pkg::cmd_t hold;
  logic             useful;
  logic             drain;

  // An item is useful when it brings a byte or ends the message.
  assign useful     = hold.has_byte | hold.eom;
  assign push_valid = hold_valid & useful;
  assign push_cmd   = hold;
  assign drain      = hold_valid & (~useful | push_ready);
  assign item_ready = ~hold_valid | drain;

  // Holding register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      hold_valid <= 1'b1;
    end else if (drain) begin
      hold_valid <= 1'b0;
    end
  end

  // Holding register payload, classified into a command.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold.data_byte <= item.data_byte;
      hold.has_byte  <= item.byte_present;
      hold.eom       <= item.end_of_message;
    end
  end

endmodule

// ===== rtl/sha1md_queue.sv =====
// Short command queue between the front and back ends.
// Depends on sha1md_pkg for the command type and depth.
module sha1md_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  sha1md_pkg::cmd_t push_cmd,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sha1md_pkg::cmd_t pop_cmd
);

  sha1md_pkg::cmd_t                 slots [sha1md_pkg::QUEUE_DEPTH];
  logic [sha1md_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sha1md_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sha1md_pkg::QPTR_W:0]     fill;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (fill != (sha1md_pkg::QPTR_W+1)'(sha1md_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/sha1md_core.sv =====
// Back end: packs bytes into the block, pads the message, runs the
// 80 compression rounds and presents the digest. Depends on sha1md_pkg.
module sha1md_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  sha1md_pkg::cmd_t      cmd,
  output logic                  digest_valid,
  input  logic                  digest_ready,
  output sha1md_pkg::out_item_t digest
);

  sha1md_pkg::state_t state, state_next;
  sha1md_pkg::state_t ret_state;

  logic [31:0] cv    [sha1md_pkg::CV_WORDS];
  logic [31:0] wv    [sha1md_pkg::CV_WORDS];
  logic [31:0] sched [sha1md_pkg::BLOCK_WORDS];
  logic [23:0] word_acc;
  logic [sha1md_pkg::COUNT_W-1:0] count;
  logic [63:0] msg_bits;
  logic [6:0]  round;
  logic [2:0]  out_idx;
  logic        pad_first;
  logic        len_ok;

  logic        take_cmd;
  logic        byte_step;
  logic [7:0]  step_byte;
  logic [5:0]  pos;
  logic        eff_len;
  logic        len_byte;
  logic [2:0]  byte_sel;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] w_new;
  logic        out_done;
  logic [sha1md_pkg::COUNT_W-1:0] count_inc;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  assign pos       = count[5:0];
  assign count_inc = count + 1'b1;
  assign cmd_ready = (state == sha1md_pkg::ST_IDLE);
  assign take_cmd  = cmd_valid & cmd_ready;
  assign out_done  = digest_valid & digest_ready & (out_idx == sha1md_pkg::LAST_INDEX);

  // Padding byte selection: the marker, zeros, or a length byte.
  assign eff_len  = pad_first ? (pos[5:3] != 3'b111) : len_ok;
  assign len_byte = ~pad_first & len_ok & (pos[5:3] == 3'b111);
  assign byte_sel = ~pos[2:0];

  always_comb begin
    byte_step = 1'b0;
    step_byte = 8'h00;
    if (state == sha1md_pkg::ST_PAD) begin
      byte_step = 1'b1;
      if (pad_first) begin
        step_byte = sha1md_pkg::PAD_BYTE;
      end else if (len_byte) begin
        step_byte = msg_bits[{byte_sel, 3'b000} +: 8];
      end
    end else if (take_cmd && cmd.has_byte) begin
      byte_step = 1'b1;
      step_byte = cmd.data_byte;
    end
  end

  // Round logic on the working variables.
  always_comb begin
    if (round < 7'd20) begin
      f_val = (wv[1] & wv[2]) | (~wv[1] & wv[3]);
      k_val = sha1md_pkg::K_R0;
    end else if (round < 7'd40) begin
      f_val = wv[1] ^ wv[2] ^ wv[3];
      k_val = sha1md_pkg::K_R1;
    end else if (round < 7'd60) begin
      f_val = (wv[1] & wv[2]) | (wv[1] & wv[3]) | (wv[2] & wv[3]);
      k_val = sha1md_pkg::K_R2;
    end else begin
      f_val = wv[1] ^ wv[2] ^ wv[3];
      k_val = sha1md_pkg::K_R3;
    end
    t_val = rotl(wv[0], 5) + f_val + wv[4] + k_val + sched[0];
    w_new = rotl(sched[13] ^ sched[8] ^ sched[2] ^ sched[0], 1);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      sha1md_pkg::ST_IDLE: begin
        if (take_cmd) begin
          if (cmd.has_byte && pos == 6'd63) begin
            state_next = sha1md_pkg::ST_ROUND;
          end else if (cmd.eom) begin
            state_next = sha1md_pkg::ST_PAD;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        if (pos == 6'd63) begin
          state_next = sha1md_pkg::ST_ROUND;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        if (round == sha1md_pkg::LAST_ROUND) begin
          state_next = sha1md_pkg::ST_ADD;
        end
      end
      sha1md_pkg::ST_ADD: begin
        state_next = ret_state;
      end
      sha1md_pkg::ST_OUT: begin
        if (out_done) begin
          state_next = sha1md_pkg::ST_IDLE;
        end
      end
      default: state_next = sha1md_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1md_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Where to go after a compression finishes.
  always_ff @(posedge clk) begin
    if (state == sha1md_pkg::ST_IDLE && take_cmd) begin
      ret_state <= cmd.eom ? sha1md_pkg::ST_PAD : sha1md_pkg::ST_IDLE;
    end else if (state == sha1md_pkg::ST_PAD && pos == 6'd63) begin
      ret_state <= eff_len ? sha1md_pkg::ST_OUT : sha1md_pkg::ST_PAD;
    end
  end

  // Padding flags and the latched bit length.
  always_ff @(posedge clk) begin
    if (take_cmd && cmd.eom) begin
      msg_bits  <= {(cmd.has_byte ? count_inc : count), 3'b000};
      pad_first <= 1'b1;
      len_ok    <= 1'b0;
    end else if (state == sha1md_pkg::ST_PAD) begin
      pad_first <= 1'b0;
      len_ok    <= (pos == 6'd63) ? 1'b1 : eff_len;
    end
  end

  // Byte counter; padding bytes advance it as a position only.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (out_done) begin
      count <= '0;
    end else if (byte_step) begin
      count <= count_inc;
    end
  end

  // Byte packing and the sixteen-word schedule shift line.
  always_ff @(posedge clk) begin
    if (byte_step) begin
      word_acc <= {word_acc[15:0], step_byte};
      if (pos[1:0] == 2'b11) begin
        for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
          sched[i] <= sched[i+1];
        end
        sched[sha1md_pkg::BLOCK_WORDS-1] <= {word_acc, step_byte};
      end
    end else if (state == sha1md_pkg::ST_ROUND) begin
      for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[sha1md_pkg::BLOCK_WORDS-1] <= w_new;
    end
  end

  // Round counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
    end else if (state == sha1md_pkg::ST_ROUND) begin
      round <= (round == sha1md_pkg::LAST_ROUND) ? 7'd0 : round + 1'b1;
    end
  end

  // Working variables: loaded when a block completes, updated each round.
  always_ff @(posedge clk) begin
    if (byte_step && pos == 6'd63) begin
      for (int i = 0; i < sha1md_pkg::CV_WORDS; i++) begin
        wv[i] <= cv[i];
      end
    end else if (state == sha1md_pkg::ST_ROUND) begin
      wv[0] <= t_val;
      wv[1] <= wv[0];
      wv[2] <= rotl(wv[1], 30);
      wv[3] <= wv[2];
      wv[4] <= wv[3];
    end
  end

  // Chaining values: accumulate after a block, restart after the digest.
  always_ff @(posedge clk) begin
    if (rst || out_done) begin
      for (int i = 0; i < sha1md_pkg::CV_WORDS; i++) begin
        cv[i] <= sha1md_pkg::CV_INIT[i];
      end
    end else if (state == sha1md_pkg::ST_ADD) begin
      for (int i = 0; i < sha1md_pkg::CV_WORDS; i++) begin
        cv[i] <= cv[i] + wv[i];
      end
    end
  end

  // Digest word index.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_idx <= '0;
    end else if (digest_valid && digest_ready) begin
      out_idx <= out_done ? 3'd0 : out_idx + 1'b1;
    end
  end

  assign digest_valid       = (state == sha1md_pkg::ST_OUT);
  assign digest.digest_word = cv[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == sha1md_pkg::LAST_INDEX);

endmodule

// ===== rtl/sha1md_checker.sv =====
// Port-level checks for the SHA-1 message digest unit, bound to the top.
// Depends on sha1md_pkg and sha1_message_digest_unit.
module sha1md_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  digest_valid,
  input logic                  digest_ready,
  input sha1md_pkg::out_item_t digest
);

  // A stalled digest word stays presented and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest))
    else $error("digest word changed while stalled");

  // The last-word flag marks exactly the fifth word.
  assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (digest.last_word == (digest.word_index == sha1md_pkg::LAST_INDEX)))
    else $error("last_word does not match word_index");

  // Words of one digest follow each other without a gap, in order.
  assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !digest.last_word |=>
      digest_valid && (digest.word_index == $past(digest.word_index) + 3'd1))
    else $error("digest words out of sequence");

  // A digest always starts at word zero.
  assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> (digest.word_index == 3'd0))
    else $error("digest did not start at word zero");

endmodule

bind sha1_message_digest_unit sha1md_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .digest_valid (digest_valid),
  .digest_ready (digest_ready),
  .digest       (digest)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for sha1_message_digest_unit: random byte messages in,
// digest words out, checked against a SHA-1 predictor kept in this file.
// Depends on rtl/sha1md_pkg.sv for the item types and on the unit's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // SHA-1 constants used by the predictor.
  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [31:0] ROUND_K0 = 32'h5a827999;
  localparam logic [31:0] ROUND_K1 = 32'h6ed9eba1;
  localparam logic [31:0] ROUND_K2 = 32'h8f1bbcdc;
  localparam logic [31:0] ROUND_K3 = 32'hca62c1d6;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  // Message lengths around the one-block and two-block padding limits.
  localparam int PAD_LENGTHS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  localparam int RANDOM_ITEMS = 215;
  localparam int IDLE_PERCENT = 28;
  localparam int MAX_REPORTS  = 10;
  localparam int EXPECT_DEPTH = 64;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  sha1md_pkg::in_item_t  item;
  logic                  digest_valid;
  logic                  digest_ready;
  sha1md_pkg::out_item_t digest;

  // Predictor state: chaining words, block under construction, byte count.
  logic [31:0] sha_chain [5];
  logic [31:0] msg_words [16];
  logic [60:0] msg_bytes;

  // Expected digest words, kept in a ring with running head and tail counts.
  sha1md_pkg::out_item_t expect_store [EXPECT_DEPTH];
  int                    expect_head = 0;
  int                    expect_tail = 0;
  int                    error_count = 0;
  logic                  full_rate;

  sha1_message_digest_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

  // Free-running 10 ns clock.
  always #5 clk = ~clk;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One 80-round compression of the current block into the chaining words.
  function automatic void compress_msg_block();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) sched[i] = msg_words[i];
    for (int i = 16; i < 80; i++) begin
      sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
    end
    a = sha_chain[0];
    b = sha_chain[1];
    c = sha_chain[2];
    d = sha_chain[3];
    e = sha_chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = ROUND_K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = ROUND_K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = ROUND_K2;
      end else begin
        f = b ^ c ^ d;
        k = ROUND_K3;
      end
      t = rotl(a, 5) + f + e + k + sched[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    sha_chain[0] += a;
    sha_chain[1] += b;
    sha_chain[2] += c;
    sha_chain[3] += d;
    sha_chain[4] += e;
  endfunction

  // Bytes go big-endian into the block words; the first byte of a word clears it.
  function automatic void place_msg_byte(int pos, logic [7:0] value);
    int shift;
    shift = (3 - pos % 4) * 8;
    if (pos % 4 == 0) msg_words[pos / 4] = 32'(value) << shift;
    else msg_words[pos / 4] |= 32'(value) << shift;
  endfunction

  // Updates the predictor with one accepted item and queues any digest words.
  function automatic void predict_item(sha1md_pkg::in_item_t it);
    int                    pos;
    logic [63:0]           bit_len;
    sha1md_pkg::out_item_t word;
    if (it.byte_present) begin
      pos = int'(msg_bytes[5:0]);
      place_msg_byte(pos, it.data_byte);
      msg_bytes = msg_bytes + 1'b1;
      if (pos == 63) compress_msg_block();
    end
    if (it.end_of_message) begin
      pos = int'(msg_bytes[5:0]);
      bit_len = {msg_bytes, 3'b000};
      place_msg_byte(pos, PAD_MARK);
      pos++;
      // No room left for the length field: close this block with zeros first.
      if (pos > 56) begin
        while (pos < 64) begin
          place_msg_byte(pos, 8'h00);
          pos++;
        end
        compress_msg_block();
        pos = 0;
      end
      while (pos < 56) begin
        place_msg_byte(pos, 8'h00);
        pos++;
      end
      for (int i = 0; i < 8; i++) place_msg_byte(56 + i, bit_len[8*(7-i) +: 8]);
      compress_msg_block();
      for (int i = 0; i < 5; i++) begin
        word.digest_word = sha_chain[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 4);
        expect_store[expect_tail % EXPECT_DEPTH] = word;
        expect_tail++;
      end
      sha_chain = SHA1_IV;
      msg_bytes = '0;
    end
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic sha1md_pkg::in_item_t make_item(logic [7:0] value, logic present,
                                                     logic last);
    sha1md_pkg::in_item_t it;
    it.data_byte      = value;
    it.byte_present   = present;
    it.end_of_message = last;
    return it;
  endfunction

  // Offers one item, holding it until the unit takes it, then predicts it.
  task automatic send_item(input sha1md_pkg::in_item_t it);
    if (!full_rate) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_item(it);
  endtask

  // Sends one message of random bytes with a few dropped items mixed in.
  // Returns the number of items sent, dropped ones included.
  task automatic send_random_message(input int len, output int sent);
    logic joined;
    sent = 0;
    joined = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(make_item(8'($urandom), 1'b0, 1'b0));
        sent++;
      end
      send_item(make_item(8'($urandom), 1'b1, joined && (n == len - 1)));
      sent++;
    end
    if (!joined) begin
      send_item(make_item(8'($urandom), 1'b0, 1'b1));
      sent++;
    end
  endtask

  // End mark with no byte right after reset gives the empty-message digest.
  task automatic test_empty_message();
    send_item(make_item(8'h00, 1'b0, 1'b1));
    send_item(make_item(8'hff, 1'b0, 1'b1));
  endtask

  // Items with neither byte nor end mark are dropped; the last byte rides
  // on the end item.
  task automatic test_ignored_items();
    send_item(make_item(8'h61, 1'b1, 1'b0));
    send_item(make_item(8'hff, 1'b0, 1'b0));
    send_item(make_item(8'h62, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b0, 1'b0));
    send_item(make_item(8'h63, 1'b1, 1'b1));
  endtask

  task automatic test_byte_extremes();
    send_item(make_item(8'h00, 1'b1, 1'b0));
    send_item(make_item(8'hff, 1'b1, 1'b0));
    send_item(make_item(8'h80, 1'b1, 1'b0));
    send_item(make_item(8'h7f, 1'b1, 1'b0));
    send_item(make_item(8'h01, 1'b1, 1'b0));
    send_item(make_item(8'h5a, 1'b0, 1'b1));
  endtask

  // One-byte messages back to back check the return to the initial state.
  task automatic test_back_to_back_digests();
    send_item(make_item(8'h78, 1'b1, 1'b1));
    send_item(make_item(8'h79, 1'b1, 1'b1));
  endtask

  // Random lengths, weighted toward the padding limits; the first stretch
  // runs with neither side idling. A message that would overrun the budget is shortened.
  task automatic test_random_messages();
    int sent;
    int msgs;
    int len;
    int count;
    sent = 0;
    msgs = 0;
    full_rate = 1'b1;
    while (sent < RANDOM_ITEMS || msgs < 10) begin
      if (sent >= 70) full_rate = 1'b0;
      if ($urandom_range(0, 9) < 3) len = PAD_LENGTHS[$urandom_range(0, 7)];
      else len = $urandom_range(0, 24);
      if (len > RANDOM_ITEMS - sent - 1) begin
        len = (RANDOM_ITEMS - sent > 1) ? RANDOM_ITEMS - sent - 1 : 0;
      end
      send_random_message(len, count);
      sent += count;
      msgs++;
    end
    full_rate = 1'b0;
  endtask

  // Digest side: random stalls, and each accepted word checked in order.
  always @(posedge clk) begin : check_digest
    sha1md_pkg::out_item_t want;
    if (rst) begin
      digest_ready <= 1'b0;
    end else begin
      if (digest_valid && digest_ready) begin
        if (expect_head == expect_tail) begin
          report_error($sformatf("unexpected digest item: word %h index %0d last %b",
                                 digest.digest_word, digest.word_index, digest.last_word));
        end else begin
          want = expect_store[expect_head % EXPECT_DEPTH];
          expect_head++;
          if (digest.digest_word !== want.digest_word ||
              digest.word_index !== want.word_index ||
              digest.last_word !== want.last_word) begin
            report_error($sformatf(
              "digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
              want.digest_word, want.word_index, want.last_word,
              digest.digest_word, digest.word_index, digest.last_word));
          end
        end
      end
      digest_ready <= full_rate || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Main sequence: reset, directed tests, random messages, drain, verdict.
  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    full_rate    = 1'b0;
    sha_chain    = SHA1_IV;
    msg_bytes    = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_message();
    test_ignored_items();
    test_byte_extremes();
    test_back_to_back_digests();
    test_random_messages();

    item_valid <= 1'b0;
    while (expect_head != expect_tail) @(posedge clk);
    // Room for a stray word after the last expected one.
    repeat (300) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake or missing digest words.
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
